>>> src/dfv_pkg.sv
`default_nettype none

package dfv_pkg;

  // Forest shape; the item fields are sized for these values
  localparam int TREE_COUNT = 10;
  localparam int TREE_DEPTH = 3;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_WRITE_NODE = 2'd0,
    OP_WRITE_LEAF = 2'd1,
    OP_CLASSIFY   = 2'd2
  } op_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  // One input transfer
  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         tree_index;
    logic [2:0]         node_index;
    logic               feature_select;
    logic signed [15:0] split_threshold;
    logic               leaf_class;
    logic signed [15:0] feature_zero;
    logic signed [15:0] feature_one;
  } in_item_t;

  // One result transfer
  typedef struct packed {
    logic       predicted_class;
    logic [3:0] votes_for_one;
  } out_item_t;

  // Internal node word: feature select over signed Q7.8 threshold
  typedef struct packed {
    logic               feat_sel;
    logic signed [15:0] thresh;
  } node_word_t;

  localparam int VOTE_OUT_MAX = 15;

endpackage

`default_nettype wire

>>> src/dfv_node_store.sv
`default_nettype none

// Split and leaf stores: one write port and one registered read port each
module dfv_node_store #(
  parameter int SPLIT_DEPTH = 70,
  parameter int LEAF_DEPTH  = 80,
  localparam int SA_W = (SPLIT_DEPTH > 1) ? $clog2(SPLIT_DEPTH) : 1,
  localparam int LA_W = (LEAF_DEPTH > 1) ? $clog2(LEAF_DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                split_we,
  input  wire logic [SA_W-1:0]     split_waddr,
  input  wire dfv_pkg::node_word_t split_wdata,
  input  wire logic [SA_W-1:0]     split_raddr,
  output dfv_pkg::node_word_t      split_rdata,
  input  wire logic                leaf_we,
  input  wire logic [LA_W-1:0]     leaf_waddr,
  input  wire logic                leaf_wdata,
  input  wire logic [LA_W-1:0]     leaf_raddr,
  output logic                     leaf_rdata
);

  dfv_pkg::node_word_t split_mem [SPLIT_DEPTH];
  logic                leaf_mem  [LEAF_DEPTH];

  dfv_pkg::node_word_t split_rdata_r;
  logic                leaf_rdata_r;

  // Split store
  always_ff @(posedge clk) begin
    if (split_we) begin
      split_mem[split_waddr] <= split_wdata;
    end
    split_rdata_r <= split_mem[split_raddr];
  end

  // Leaf store
  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[leaf_waddr] <= leaf_wdata;
    end
    leaf_rdata_r <= leaf_mem[leaf_raddr];
  end

  assign split_rdata = split_rdata_r;
  assign leaf_rdata  = leaf_rdata_r;

endmodule

`default_nettype wire

>>> src/decision_forest_vote_classifier_top.sv
`default_nettype none

// Decision forest vote classifier.
// Input channel: an item transfers on a rising edge with start high and busy
// low. Operation write-node stores a feature select and Q7.8 threshold for
// one internal node, write-leaf stores one leaf class bit; both finish in the
// transfer cycle and give no result. Writes outside the forest are dropped.
// Classify walks every tree, one node read per cycle from the split store,
// then one leaf read; busy stays high for the whole walk. The result strobe
// out_valid rises in the cycle after the last leaf read, as busy falls; the
// next item may transfer in that same cycle. The walk is bound by the single
// read port of the split store, where each node address depends on the
// previous compare.
// Result channel: out_item is valid for exactly one cycle with out_valid;
// the receiver cannot stall it. votes_for_one saturates at 15, a tie
// predicts class 1.
// Reset clears the sequencer and the result strobe; node stores are not
// cleared and must be written before use.
module decision_forest_vote_classifier_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire dfv_pkg::in_item_t in_item,
  output logic                   out_valid,
  output dfv_pkg::out_item_t     out_item
);

  localparam int TREE_COUNT  = dfv_pkg::TREE_COUNT;
  localparam int TREE_DEPTH  = dfv_pkg::TREE_DEPTH;
  localparam int INTERNAL    = (1 << TREE_DEPTH) - 1;
  localparam int LEAVES      = 1 << TREE_DEPTH;
  localparam int SPLIT_DEPTH = TREE_COUNT * INTERNAL;
  localparam int LEAF_DEPTH  = TREE_COUNT * LEAVES;
  localparam int SA_W = (SPLIT_DEPTH > 1) ? $clog2(SPLIT_DEPTH) : 1;
  localparam int LA_W = (LEAF_DEPTH > 1) ? $clog2(LEAF_DEPTH) : 1;
  localparam int TC_W = (TREE_COUNT > 1) ? $clog2(TREE_COUNT) : 1;
  localparam int LV_W = $clog2(TREE_DEPTH + 1);
  localparam int VW   = $clog2(TREE_COUNT + 1);
  localparam int PW   = TREE_DEPTH;

  dfv_pkg::state_e    state_r, state_nxt;
  logic [TC_W-1:0]    tree_r, tree_nxt;
  logic [LV_W-1:0]    lvl_r, lvl_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [PW-1:0]      path_r, path_nxt;
  logic [SA_W-1:0]    split_base_r, split_base_nxt;
  logic [LA_W-1:0]    leaf_base_r, leaf_base_nxt;
  logic [VW-1:0]      votes_r, votes_nxt;
  logic signed [15:0] feat0_r, feat0_nxt;
  logic signed [15:0] feat1_r, feat1_nxt;
  logic               out_valid_r, out_valid_nxt;
  dfv_pkg::out_item_t out_item_r, out_item_nxt;

  logic                accept;
  logic                split_we;
  logic                leaf_we;
  logic [SA_W-1:0]     split_waddr;
  logic [LA_W-1:0]     leaf_waddr;
  dfv_pkg::node_word_t split_wdata;
  logic [SA_W-1:0]     split_raddr;
  logic [LA_W-1:0]     leaf_raddr;
  dfv_pkg::node_word_t rd_node;
  logic                rd_leaf;

  logic signed [15:0]  sel_feat;
  logic                go_right;
  logic [PW:0]         child_ext;
  logic [PW-1:0]       child;
  logic [PW-1:0]       path_step;
  logic                at_leaf;
  logic                last_level;
  logic                last_tree;
  logic [VW-1:0]       vote_sum;
  logic [SA_W-1:0]     split_base_step;
  logic [LA_W-1:0]     leaf_base_step;
  logic [31:0]         split_wfull;
  logic [31:0]         leaf_wfull;

  assign accept = start && !busy;
  assign busy   = (state_r != dfv_pkg::ST_IDLE);

  // Load path: range check and flat store addresses
  assign split_wfull = 32'(in_item.tree_index) * 32'(INTERNAL) + 32'(in_item.node_index);
  assign leaf_wfull  = 32'(in_item.tree_index) * 32'(LEAVES) + 32'(in_item.node_index);
  assign split_waddr = split_wfull[SA_W-1:0];
  assign leaf_waddr  = leaf_wfull[LA_W-1:0];
  assign split_wdata = '{feat_sel: in_item.feature_select, thresh: in_item.split_threshold};

  assign split_we = accept && (in_item.operation == dfv_pkg::OP_WRITE_NODE)
                 && (32'(in_item.tree_index) < 32'(TREE_COUNT))
                 && (32'(in_item.node_index) < 32'(INTERNAL));
  assign leaf_we  = accept && (in_item.operation == dfv_pkg::OP_WRITE_LEAF)
                 && (32'(in_item.tree_index) < 32'(TREE_COUNT))
                 && (32'(in_item.node_index) < 32'(LEAVES));

  // Node compare: left while feature is below threshold
  assign sel_feat  = rd_node.feat_sel ? feat1_r : feat0_r;
  assign go_right  = !($signed(sel_feat) < $signed(rd_node.thresh));
  assign child_ext = {pos_r, 1'b0} + (PW+1)'(1) + (PW+1)'(go_right);
  assign child     = child_ext[PW-1:0];
  assign path_step = (path_r << 1) | PW'(go_right);

  assign at_leaf    = (lvl_r == LV_W'(TREE_DEPTH));
  assign last_level = (lvl_r == LV_W'(TREE_DEPTH - 1));
  assign last_tree  = (tree_r == TC_W'(TREE_COUNT - 1));
  assign vote_sum   = votes_r + VW'(rd_leaf);

  // Tree bases wrap to zero after the last tree, ready for the next item
  assign split_base_step = last_tree ? '0 : split_base_r + SA_W'(INTERNAL);
  assign leaf_base_step  = last_tree ? '0 : leaf_base_r + LA_W'(LEAVES);

  // Read address issue: next node, leaf, or root of the next tree
  always_comb begin
    split_raddr = split_base_r;
    leaf_raddr  = leaf_base_r + LA_W'(path_step);
    if (state_r == dfv_pkg::ST_WALK) begin
      if (at_leaf) begin
        split_raddr = split_base_step;
      end else if (!last_level) begin
        split_raddr = split_base_r + SA_W'(child);
      end
    end
  end

  dfv_node_store #(
    .SPLIT_DEPTH (SPLIT_DEPTH),
    .LEAF_DEPTH  (LEAF_DEPTH)
  ) u_store (
    .clk         (clk),
    .split_we    (split_we),
    .split_waddr (split_waddr),
    .split_wdata (split_wdata),
    .split_raddr (split_raddr),
    .split_rdata (rd_node),
    .leaf_we     (leaf_we),
    .leaf_waddr  (leaf_waddr),
    .leaf_wdata  (in_item.leaf_class),
    .leaf_raddr  (leaf_raddr),
    .leaf_rdata  (rd_leaf)
  );

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    tree_nxt       = tree_r;
    lvl_nxt        = lvl_r;
    pos_nxt        = pos_r;
    path_nxt       = path_r;
    split_base_nxt = split_base_r;
    leaf_base_nxt  = leaf_base_r;
    votes_nxt      = votes_r;
    feat0_nxt      = feat0_r;
    feat1_nxt      = feat1_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    unique case (state_r)
      dfv_pkg::ST_IDLE: begin
        if (accept && (in_item.operation == dfv_pkg::OP_CLASSIFY)) begin
          state_nxt = dfv_pkg::ST_WALK;
          tree_nxt  = '0;
          lvl_nxt   = '0;
          pos_nxt   = '0;
          path_nxt  = '0;
          votes_nxt = '0;
          feat0_nxt = in_item.feature_zero;
          feat1_nxt = in_item.feature_one;
        end
      end
      dfv_pkg::ST_WALK: begin
        if (!at_leaf) begin
          pos_nxt  = child;
          path_nxt = path_step;
          lvl_nxt  = lvl_r + LV_W'(1);
        end else begin
          split_base_nxt = split_base_step;
          leaf_base_nxt  = leaf_base_step;
          votes_nxt      = vote_sum;
          lvl_nxt        = '0;
          pos_nxt        = '0;
          path_nxt       = '0;
          if (last_tree) begin
            state_nxt     = dfv_pkg::ST_IDLE;
            tree_nxt      = '0;
            out_valid_nxt = 1'b1;
            out_item_nxt.predicted_class = !((32'(vote_sum) << 1) < 32'(TREE_COUNT));
            out_item_nxt.votes_for_one   = (32'(vote_sum) > 32'(dfv_pkg::VOTE_OUT_MAX))
                                         ? 4'(dfv_pkg::VOTE_OUT_MAX) : 4'(vote_sum);
          end else begin
            tree_nxt = tree_r + TC_W'(1);
          end
        end
      end
      default: begin
        state_nxt = dfv_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dfv_pkg::ST_IDLE;
      tree_r       <= '0;
      lvl_r        <= '0;
      pos_r        <= '0;
      path_r       <= '0;
      split_base_r <= '0;
      leaf_base_r  <= '0;
      votes_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tree_r       <= tree_nxt;
      lvl_r        <= lvl_nxt;
      pos_r        <= pos_nxt;
      path_r       <= path_nxt;
      split_base_r <= split_base_nxt;
      leaf_base_r  <= leaf_base_nxt;
      votes_r      <= votes_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    feat0_r    <= feat0_nxt;
    feat1_r    <= feat1_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  // Result strobe is a single-cycle pulse
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // A result only follows the last leaf read of a walk
  a_strobe_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == dfv_pkg::ST_WALK) && $past(at_leaf) && $past(last_tree))
    else $error("result without a finished walk");

  // Vote count cannot exceed the tree count
  a_votes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_item.votes_for_one) <= 32'(TREE_COUNT)))
    else $error("vote count exceeds tree count");

  // Walk counters stay inside the forest
  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dfv_pkg::ST_WALK) |-> (32'(lvl_r) <= 32'(TREE_DEPTH))
                                   && (32'(tree_r) < 32'(TREE_COUNT)))
    else $error("walk counter out of range");

  // A new walk always starts at the root of tree zero
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> (tree_r == '0) && (lvl_r == '0) && (split_base_r == '0)
                  && (leaf_base_r == '0))
    else $error("walk started away from the first root");
`endif

endmodule

`default_nettype wire

>>> bench/decision_forest_vote_classifier_top_tb.sv
`default_nettype none

module decision_forest_vote_classifier_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TREES            = dfv_pkg::TREE_COUNT;
  localparam int DEPTH            = dfv_pkg::TREE_DEPTH;
  localparam int NODES_PER_TREE   = (1 << DEPTH) - 1;
  localparam int LEAVES_PER_TREE  = 1 << DEPTH;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_PER_PHASE = 190;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One row of the directed table; pinned rows carry a hand-typed result
  typedef struct {
    logic [1:0] op;
    int         tree;
    int         node;
    int         fsel;
    int         thr;
    int         leaf;
    int         f0;
    int         f1;
    bit         pinned;
    int         cls;
    int         votes;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  dfv_pkg::in_item_t  in_item;
  logic               out_valid;
  dfv_pkg::out_item_t out_item;

  // Mirror of the forest and the results still owed by the block
  dfv_pkg::node_word_t node_mirror [TREES*NODES_PER_TREE];
  logic                leaf_mirror [TREES*LEAVES_PER_TREE];
  dfv_pkg::out_item_t  vote_expect_q [$];

  bit                 pin_valid;
  dfv_pkg::out_item_t pin_result;

  int errors;
  int quiet_cycles;
  int n_xfers;
  int n_classify;
  int n_ties;
  int n_unanimous;
  int n_writes;
  int n_unused;

  // Forest loaded uniformly (feature 0, threshold 0, every leaf class 1)
  // before this table runs, so pinned results follow directly.
  dir_row_t dir_tab [20] = '{
    '{dfv_pkg::OP_CLASSIFY,   0, 0, 0,      0, 0, -32768,  32767, 1, 1, 10},
    '{dfv_pkg::OP_CLASSIFY,   0, 0, 0,      0, 0,  32767, -32768, 1, 1, 10},
    '{dfv_pkg::OP_CLASSIFY,   0, 0, 0,      0, 0,      0,      0, 1, 1, 10},
    '{OP_UNUSED,              0, 0, 0,      0, 0,     -1,     -1, 0, 0,  0},
    '{dfv_pkg::OP_WRITE_LEAF, 10, 0, 0,     0, 0,      0,      0, 0, 0,  0},
    '{dfv_pkg::OP_WRITE_LEAF, 15, 7, 0,     0, 0,      0,      0, 0, 0,  0},
    '{dfv_pkg::OP_WRITE_NODE, 10, 0, 1, -32768, 0,     0,      0, 0, 0,  0},
    '{dfv_pkg::OP_WRITE_NODE, 0, 7, 1,  32767, 0,      0,      0, 0, 0,  0},
    '{dfv_pkg::OP_CLASSIFY,   0, 0, 0,      0, 0,     -1,      0, 1, 1, 10},
    '{dfv_pkg::OP_WRITE_LEAF, 0, 0, 0,      0, 0,      0,      0, 0, 0,  0},
    '{dfv_pkg::OP_WRITE_LEAF, 9, 0, 0,      0, 0,      0,      0, 0, 0,  0},
    '{dfv_pkg::OP_CLASSIFY,   0, 0, 0,      0, 0, -32768,      0, 1, 1,  8},
    '{dfv_pkg::OP_WRITE_NODE, 0, 0, 1, -32768, 0,      0,      0, 0, 0,  0},
    '{dfv_pkg::OP_WRITE_NODE, 9, 0, 1,  32767, 0,      0,      0, 0, 0,  0},
    '{dfv_pkg::OP_CLASSIFY,   0, 0, 0,      0, 0,     -5,  32767, 0, 0,  0},
    '{dfv_pkg::OP_CLASSIFY,   0, 0, 0,      0, 0,     -5, -32768, 0, 0,  0},
    '{dfv_pkg::OP_WRITE_LEAF, 3, 7, 0,      0, 0,      0,      0, 0, 0,  0},
    '{dfv_pkg::OP_WRITE_NODE, 3, 2, 0,    100, 0,      0,      0, 0, 0,  0},
    '{dfv_pkg::OP_CLASSIFY,   0, 0, 0,      0, 0,    100,      0, 0, 0,  0},
    '{dfv_pkg::OP_CLASSIFY,   0, 0, 0,      0, 0,     99,      0, 0, 0,  0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  decision_forest_vote_classifier_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Apply one item to the mirror; returns 1 when the item yields a vote result
  function automatic bit forest_vote_predict(input dfv_pkg::in_item_t it,
                                             output dfv_pkg::out_item_t res);
    int                  ones;
    int                  zeros;
    int                  pos;
    dfv_pkg::node_word_t w;
    logic signed [15:0]  feat;
    logic signed [15:0]  thr;
    res = '0;
    case (it.operation)
      dfv_pkg::OP_WRITE_NODE: begin
        if (it.tree_index < TREES && it.node_index < NODES_PER_TREE) begin
          w.feat_sel = it.feature_select;
          w.thresh   = it.split_threshold;
          node_mirror[it.tree_index*NODES_PER_TREE + it.node_index] = w;
        end
        return 1'b0;
      end
      dfv_pkg::OP_WRITE_LEAF: begin
        if (it.tree_index < TREES && it.node_index < LEAVES_PER_TREE)
          leaf_mirror[it.tree_index*LEAVES_PER_TREE + it.node_index] = it.leaf_class;
        return 1'b0;
      end
      dfv_pkg::OP_CLASSIFY: begin
        ones  = 0;
        zeros = 0;
        for (int t = 0; t < TREES; t++) begin
          pos = 0;
          for (int lvl = 0; lvl < DEPTH; lvl++) begin
            w    = node_mirror[t*NODES_PER_TREE + pos];
            thr  = w.thresh;
            feat = w.feat_sel ? it.feature_one : it.feature_zero;
            pos  = (feat < thr) ? 2*pos + 1 : 2*pos + 2;
          end
          if (leaf_mirror[t*LEAVES_PER_TREE + pos - NODES_PER_TREE]) ones++;
          else zeros++;
        end
        // tie goes to class 1
        res.predicted_class = (zeros > ones) ? 1'b0 : 1'b1;
        res.votes_for_one   = 4'((ones > dfv_pkg::VOTE_OUT_MAX) ? dfv_pkg::VOTE_OUT_MAX : ones);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Transfer monitor and scoreboard
  always @(posedge clk) begin : monitor
    dfv_pkg::out_item_t want;
    dfv_pkg::out_item_t pred;
    bit                 has;
    bit                 xfer;
    if (rst_n) begin
      xfer = 1'b0;
      if (out_valid) begin
        xfer = 1'b1;
        if (vote_expect_q.size() == 0) begin
          report_mismatch("result with no classification pending, votes",
                          out_item.votes_for_one, -1);
        end else begin
          want = vote_expect_q.pop_front();
          if (out_item.predicted_class !== want.predicted_class)
            report_mismatch("predicted_class", out_item.predicted_class,
                            want.predicted_class);
          if (out_item.votes_for_one !== want.votes_for_one)
            report_mismatch("votes_for_one", out_item.votes_for_one, want.votes_for_one);
        end
      end
      if (start && !busy) begin
        xfer = 1'b1;
        n_xfers++;
        has = forest_vote_predict(in_item, pred);
        if (has) begin
          vote_expect_q.push_back(pin_valid ? pin_result : pred);
          n_classify++;
          if (2*pred.votes_for_one == TREES) n_ties++;
          if (pred.votes_for_one == 0 || pred.votes_for_one == TREES) n_unanimous++;
        end else if (in_item.operation == OP_UNUSED) begin
          n_unused++;
        end else begin
          n_writes++;
        end
      end
      quiet_cycles = xfer ? 0 : quiet_cycles + 1;
    end
  end

  // Mostly short gaps, a few long ones; none in steady phases
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Present one item after a gap and hold it until the transfer
  task automatic send_item(input dfv_pkg::in_item_t it, input bit pinned,
                           input dfv_pkg::out_item_t want, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    in_item    <= it;
    pin_valid  <= pinned;
    pin_result <= want;
    do @(posedge clk); while (busy);
  endtask

  // Hold off the sender until every owed result has arrived
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (vote_expect_q.size() != 0) @(negedge clk);
  endtask

  // Leaf sweep with a class bias, then a random mix of writes, classifies and noise
  task automatic run_phase(input int one_pct, input bit steady);
    dfv_pkg::in_item_t   it;
    logic [63:0]         raw;
    dfv_pkg::node_word_t pick;
    int                  r;
    for (int t = 0; t < TREES; t++) begin
      for (int l = 0; l < LEAVES_PER_TREE; l++) begin
        raw = {$urandom, $urandom};
        it = raw[$bits(dfv_pkg::in_item_t)-1:0];
        it.operation  = dfv_pkg::OP_WRITE_LEAF;
        it.tree_index = 4'(t);
        it.node_index = 3'(l);
        it.leaf_class = ($urandom_range(0, 99) < one_pct);
        send_item(it, 1'b0, '0, pick_gap(steady));
      end
    end
    repeat (RANDOM_PER_PHASE) begin
      raw = {$urandom, $urandom};
      it = raw[$bits(dfv_pkg::in_item_t)-1:0];
      r = $urandom_range(0, 99);
      if (r < 45) begin
        it.operation = dfv_pkg::OP_CLASSIFY;
        // land on or next to a stored threshold now and then
        if ($urandom_range(0, 2) == 0) begin
          pick = node_mirror[$urandom_range(0, TREES*NODES_PER_TREE - 1)];
          if (pick.feat_sel)
            it.feature_one = pick.thresh + 16'($urandom_range(0, 2)) - 16'd1;
          else
            it.feature_zero = pick.thresh + 16'($urandom_range(0, 2)) - 16'd1;
        end
      end else if (r < 70) begin
        it.operation  = dfv_pkg::OP_WRITE_NODE;
        it.tree_index = 4'($urandom_range(0, TREES - 1));
        it.node_index = 3'($urandom_range(0, NODES_PER_TREE - 1));
        if ($urandom_range(0, 9) == 0)
          it.split_threshold = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end else if (r < 90) begin
        it.operation  = dfv_pkg::OP_WRITE_LEAF;
        it.tree_index = 4'($urandom_range(0, TREES - 1));
        it.node_index = 3'($urandom_range(0, LEAVES_PER_TREE - 1));
        it.leaf_class = ($urandom_range(0, 99) < one_pct);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            it.operation  = $urandom_range(0, 1) ? dfv_pkg::OP_WRITE_LEAF
                                                 : dfv_pkg::OP_WRITE_NODE;
            it.tree_index = 4'($urandom_range(TREES, 15));
          end
          1: begin
            it.operation  = dfv_pkg::OP_WRITE_NODE;
            it.tree_index = 4'($urandom_range(0, TREES - 1));
            it.node_index = 3'(NODES_PER_TREE);
          end
          default: it.operation = OP_UNUSED;
        endcase
      end
      send_item(it, 1'b0, '0, pick_gap(steady));
    end
  endtask

  // Stimulus
  initial begin : stimulus
    dfv_pkg::in_item_t  it;
    dfv_pkg::out_item_t want;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    pin_valid  = 1'b0;
    pin_result = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // uniform forest so that no classify reads an unwritten entry
    for (int t = 0; t < TREES; t++) begin
      for (int n = 0; n < NODES_PER_TREE; n++) begin
        it = '0;
        it.operation  = dfv_pkg::OP_WRITE_NODE;
        it.tree_index = 4'(t);
        it.node_index = 3'(n);
        send_item(it, 1'b0, '0, pick_gap(1'b0));
      end
      for (int l = 0; l < LEAVES_PER_TREE; l++) begin
        it = '0;
        it.operation  = dfv_pkg::OP_WRITE_LEAF;
        it.tree_index = 4'(t);
        it.node_index = 3'(l);
        it.leaf_class = 1'b1;
        send_item(it, 1'b0, '0, pick_gap(1'b0));
      end
    end

    // directed table
    foreach (dir_tab[i]) begin
      it = '0;
      it.operation       = dir_tab[i].op;
      it.tree_index      = 4'(dir_tab[i].tree);
      it.node_index      = 3'(dir_tab[i].node);
      it.feature_select  = 1'(dir_tab[i].fsel);
      it.split_threshold = 16'(dir_tab[i].thr);
      it.leaf_class      = 1'(dir_tab[i].leaf);
      it.feature_zero    = 16'(dir_tab[i].f0);
      it.feature_one     = 16'(dir_tab[i].f1);
      want.predicted_class = 1'(dir_tab[i].cls);
      want.votes_for_one   = 4'(dir_tab[i].votes);
      send_item(it, dir_tab[i].pinned, want, pick_gap(1'b0));
    end
    wait_drained();

    // random phases: all-zero, all-one and mixed leaf populations
    run_phase(0, 1'b0);
    wait_drained();
    run_phase(100, 1'b0);
    wait_drained();
    run_phase(50, 1'b1);
    wait_drained();
    run_phase(50, 1'b0);
    wait_drained();
    run_phase(20, 1'b0);
    wait_drained();
    run_phase(80, 1'b0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (vote_expect_q.size() != 0)
      report_mismatch("results never delivered", 0, vote_expect_q.size());

    $display("Run covered %0d transfers: %0d classifications (%0d ties, %0d unanimous),",
             n_xfers, n_classify, n_ties, n_unanimous);
    $display("%0d node/leaf writes incl. out-of-range drops, %0d unused-opcode items.",
             n_writes, n_unused);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: stop when no transfer happens for too long
  initial begin : watchdog
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
